// File: rtl/pmwa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared constants for the power meter window accumulator
// widths of the running sums and configuration register indexes; no dependencies

package pmwa_pkg;

    // running sum widths per channel
    localparam int SUM_W    = 36;   // sum of centered v and of centered i
    localparam int SQ_W     = 47;   // sums of squares and of v*i
    localparam int SQ_OUT_W = 46;   // reported width of the sums of squares
    localparam int PWR_W    = 47;   // reported width of the v*i sum

    // configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 12;
    localparam int WIN_W      = 8;
    localparam int MID_W      = 12;

    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIDPOINT = 1'd1;

    localparam logic [WIN_W-1:0] WINDOW_RESET   = 8'd125;
    localparam logic [MID_W-1:0] MIDPOINT_RESET = 12'd2048;

    localparam int CHAN_W = 2;

endpackage

`default_nettype wire

// File: rtl/power_meter_window_accumulator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// power meter window accumulator: per-channel sums of v, i, v^2, i^2 and v*i
// closed by rising voltage zero crossings; uses pmwa_pkg

// One sample pair is taken every clock cycle while s_axis_tready is high. A
// beat goes through an input register, a multiply stage (centering and the
// three products) and the per-channel accumulate stage, which loads the
// result register from which a closing window appears on the master side.
// Beats for the same channel may follow each other in consecutive cycles:
// the accumulators are read and written back in the same cycle. The result
// register frees when its beat is taken; while it stays full and unread the
// pipeline holds and s_axis_tready drops once the input and multiply stages
// are also occupied. A channel index at or above CHANNELS is accepted and
// dropped without effect.

module power_meter_window_accumulator_core
    import pmwa_pkg::*;
#(
    parameter int CHANNELS    = 3,
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // v_sample, i_sample
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // channel
    input  wire logic [CHAN_W-1:0]     s_axis_tuser,

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // total_v, total_i, total_v_squared, total_i_squared, total_power, sample_count
    output logic [((2*SUM_W+2*SQ_OUT_W+PWR_W+COUNT_BITS+1+7)/8)*8-1:0] m_axis_tdata,
    // out_channel, count_overflow, all_ready
    output logic [CHAN_W+1:0]          m_axis_tuser
);

    localparam int CNT_W  = COUNT_BITS + 1;
    localparam int VC_W   = ((SAMPLE_BITS > MID_W) ? SAMPLE_BITS : MID_W) + 1;
    localparam int PROD_W = 2 * VC_W;
    localparam int OUT_BITS = 2*SUM_W + 2*SQ_OUT_W + PWR_W + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // configuration
    logic [WIN_W-1:0] r_cfg_window;
    logic [MID_W-1:0] r_cfg_midpoint;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_window   <= WINDOW_RESET;
            r_cfg_midpoint <= MIDPOINT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_WINDOW:   r_cfg_window   <= i_cfg_wdata[WIN_W-1:0];
                CFG_MIDPOINT: r_cfg_midpoint <= i_cfg_wdata[MID_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic r_s1_valid, r_s2_valid, r_out_valid;
    logic adv_out, s2_ready, s1_ready, s_fire, s2_fire;

    assign adv_out  = !r_out_valid || m_axis_tready;
    assign s2_ready = !r_s2_valid || adv_out;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign s_axis_tready = s1_ready;
    assign s_fire  = s_axis_tvalid && s1_ready;
    assign s2_fire = r_s2_valid && adv_out;

    // input register
    logic [CHAN_W-1:0]      r_s1_ch;
    logic [SAMPLE_BITS-1:0] r_s1_v, r_s1_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            // out-of-range channels are dropped here
            r_s1_valid <= s_fire && (32'(s_axis_tuser) < CHANNELS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_s1_ch <= s_axis_tuser;
            r_s1_v  <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_s1_i  <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
    end

    // centering and products
    logic signed [VC_W-1:0]   s1_vc, s1_ic, s1_mid;
    logic signed [PROD_W-1:0] s1_vv, s1_ii, s1_vi;

    always_comb begin
        s1_mid = $signed({{(VC_W-MID_W){1'b0}}, r_cfg_midpoint});
        s1_vc  = $signed({{(VC_W-SAMPLE_BITS){1'b0}}, r_s1_v}) - s1_mid;
        s1_ic  = $signed({{(VC_W-SAMPLE_BITS){1'b0}}, r_s1_i}) - s1_mid;
        s1_vv  = s1_vc * s1_vc;
        s1_ii  = s1_ic * s1_ic;
        s1_vi  = s1_vc * s1_ic;
    end

    logic [CHAN_W-1:0]        r_s2_ch;
    logic signed [VC_W-1:0]   r_s2_vc, r_s2_ic;
    logic signed [PROD_W-1:0] r_s2_vv, r_s2_ii, r_s2_vi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_s2_ch <= r_s1_ch;
            r_s2_vc <= s1_vc;
            r_s2_ic <= s1_ic;
            r_s2_vv <= s1_vv;
            r_s2_ii <= s1_ii;
            r_s2_vi <= s1_vi;
        end
    end

    // per-channel state
    logic [SUM_W-1:0] r_acc_v   [CHANNELS];
    logic [SUM_W-1:0] r_acc_i   [CHANNELS];
    logic [SQ_W-1:0]  r_acc_vv  [CHANNELS];
    logic [SQ_W-1:0]  r_acc_ii  [CHANNELS];
    logic [SQ_W-1:0]  r_acc_vi  [CHANNELS];
    logic [CNT_W-1:0] r_count   [CHANNELS];
    logic             r_pos     [CHANNELS];
    logic [WIN_W-1:0] r_xings   [CHANNELS];
    logic             r_ovf     [CHANNELS];

    logic [SUM_W-1:0] sel_v, sel_i, n_v, n_i;
    logic [SQ_W-1:0]  sel_vv, sel_ii, sel_vi, n_vv, n_ii, n_vi;
    logic [CNT_W-1:0] sel_count, n_count;
    logic             sel_pos, sel_ovf, n_pos, n_ovf;
    logic [WIN_W-1:0] sel_xings, n_xings;
    logic             win_close;

    always_comb begin
        sel_v = '0; sel_i = '0; sel_vv = '0; sel_ii = '0; sel_vi = '0;
        sel_count = '0; sel_pos = 1'b0; sel_xings = '0; sel_ovf = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (32'(r_s2_ch) == c) begin
                sel_v     = r_acc_v[c];
                sel_i     = r_acc_i[c];
                sel_vv    = r_acc_vv[c];
                sel_ii    = r_acc_ii[c];
                sel_vi    = r_acc_vi[c];
                sel_count = r_count[c];
                sel_pos   = r_pos[c];
                sel_xings = r_xings[c];
                sel_ovf   = r_ovf[c];
            end
        end

        n_v  = sel_v  + {{(SUM_W-VC_W){r_s2_vc[VC_W-1]}}, r_s2_vc};
        n_i  = sel_i  + {{(SUM_W-VC_W){r_s2_ic[VC_W-1]}}, r_s2_ic};
        n_vv = sel_vv + {{(SQ_W-PROD_W){r_s2_vv[PROD_W-1]}}, r_s2_vv};
        n_ii = sel_ii + {{(SQ_W-PROD_W){r_s2_ii[PROD_W-1]}}, r_s2_ii};
        n_vi = sel_vi + {{(SQ_W-PROD_W){r_s2_vi[PROD_W-1]}}, r_s2_vi};

        // count stops at 2^COUNT_BITS, which is the only value with the top bit set
        n_count = sel_count[COUNT_BITS] ? sel_count : sel_count + CNT_W'(1);
        n_ovf   = sel_ovf || sel_count[COUNT_BITS];

        n_pos   = !r_s2_vc[VC_W-1] && (r_s2_vc != '0);
        n_xings = sel_xings + WIN_W'(!sel_pos && n_pos);
        win_close = (n_xings >= r_cfg_window);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_acc_v[c]  <= '0;
                r_acc_i[c]  <= '0;
                r_acc_vv[c] <= '0;
                r_acc_ii[c] <= '0;
                r_acc_vi[c] <= '0;
                r_count[c]  <= '0;
                r_pos[c]    <= 1'b0;
                r_xings[c]  <= '0;
                r_ovf[c]    <= 1'b0;
            end
        end else if (s2_fire) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (32'(r_s2_ch) == c) begin
                    if (win_close) begin
                        r_acc_v[c]  <= '0;
                        r_acc_i[c]  <= '0;
                        r_acc_vv[c] <= '0;
                        r_acc_ii[c] <= '0;
                        r_acc_vi[c] <= '0;
                        r_count[c]  <= '0;
                        r_pos[c]    <= 1'b0;
                        r_xings[c]  <= '0;
                        r_ovf[c]    <= 1'b0;
                    end else begin
                        r_acc_v[c]  <= n_v;
                        r_acc_i[c]  <= n_i;
                        r_acc_vv[c] <= n_vv;
                        r_acc_ii[c] <= n_ii;
                        r_acc_vi[c] <= n_vi;
                        r_count[c]  <= n_count;
                        r_pos[c]    <= n_pos;
                        r_xings[c]  <= n_xings;
                        r_ovf[c]    <= n_ovf;
                    end
                end
            end
        end
    end

    // result register
    logic [CHAN_W-1:0]   r_out_ch;
    logic [SUM_W-1:0]    r_out_v, r_out_i;
    logic [SQ_OUT_W-1:0] r_out_vv, r_out_ii;
    logic [PWR_W-1:0]    r_out_vi;
    logic [CNT_W-1:0]    r_out_count;
    logic                r_out_ovf, r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_s2_valid && win_close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire && win_close) begin
            r_out_ch    <= r_s2_ch;
            r_out_v     <= n_v;
            r_out_i     <= n_i;
            r_out_vv    <= n_vv[SQ_OUT_W-1:0];
            r_out_ii    <= n_ii[SQ_OUT_W-1:0];
            r_out_vi    <= n_vi[PWR_W-1:0];
            r_out_count <= n_count;
            r_out_ovf   <= n_ovf;
            r_out_last  <= (32'(r_s2_ch) == CHANNELS - 1);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_count, r_out_vi, r_out_ii, r_out_vv,
                                         r_out_i, r_out_v});
    assign m_axis_tuser  = {r_out_last, r_out_ovf, r_out_ch};

    // checks
    a_s1_channel_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (32'(r_s1_ch) < CHANNELS))
        else $error("out-of-range channel reached the pipeline");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_ovf |-> r_out_count[COUNT_BITS])
        else $error("overflow flag set without a saturated count");

    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && !adv_out |=> r_s2_valid && $stable(r_s2_ch) && $stable(r_s2_vc))
        else $error("multiply stage changed while stalled");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid && $stable(r_out_v)
        && $stable(r_out_count))
        else $error("result register changed while not taken");

endmodule

`default_nettype wire

// File: verif/power_meter_window_accumulator_core_test.sv
`timescale 1ns / 1ps
// self-checking bench for power_meter_window_accumulator_core
// needs rtl/pmwa_pkg.sv and rtl/power_meter_window_accumulator_core.sv

module power_meter_window_accumulator_core_test;
    import pmwa_pkg::*;

    localparam int CHANNELS    = 3;
    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 24;
    localparam int S_DATA_W    = 24;
    localparam int M_DATA_W    = 240;
    localparam logic [24:0] COUNT_LIMIT = 25'd1 << COUNT_BITS;

    // result beat field offsets inside m_axis_tdata
    localparam int OFS_I   = 36;
    localparam int OFS_VSQ = 72;
    localparam int OFS_ISQ = 118;
    localparam int OFS_PWR = 164;
    localparam int OFS_CNT = 211;

    localparam int PRESSURE_PHASE = 2;
    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 8;
    localparam int IDLE_LIMIT     = 1000;

    typedef enum logic [1:0] {RDY_ALWAYS, RDY_RANDOM, RDY_SPARSE} t_ready_mode;

    typedef struct packed {
        logic [1:0]  chan;
        logic [11:0] v_code;
        logic [11:0] i_code;
    } t_sample_beat;

    typedef struct packed {
        logic [1:0]  chan;
        logic [35:0] sum_v;
        logic [35:0] sum_i;
        logic [45:0] sq_v;
        logic [45:0] sq_i;
        logic [46:0] pwr;
        logic [24:0] count;
        logic        ovf;
        logic        last_chan;
    } t_window_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;   // v_sample, i_sample
    logic [CHAN_W-1:0]     s_axis_tuser = '0;   // channel
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;        // total_v, total_i, total_v_squared,
                                                // total_i_squared, total_power, sample_count
    logic [CHAN_W+1:0]     m_axis_tuser;        // out_channel, count_overflow, all_ready

    power_meter_window_accumulator_core #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor copy of the per-channel state and the registers
    logic [35:0] run_v     [CHANNELS] = '{default: '0};
    logic [35:0] run_i     [CHANNELS] = '{default: '0};
    logic [46:0] run_sq_v  [CHANNELS] = '{default: '0};
    logic [46:0] run_sq_i  [CHANNELS] = '{default: '0};
    logic [46:0] run_pwr   [CHANNELS] = '{default: '0};
    logic [24:0] run_count [CHANNELS] = '{default: '0};
    logic        was_high  [CHANNELS] = '{default: 1'b0};
    logic [7:0]  crossings [CHANNELS] = '{default: '0};
    logic        count_sat [CHANNELS] = '{default: 1'b0};
    logic [WIN_W-1:0] window_len = WINDOW_RESET;
    logic [MID_W-1:0] mid_code   = MIDPOINT_RESET;

    t_sample_beat   beat_q[$];
    t_window_result window_q[$];
    t_sample_beat   cur_beat;

    int  queued_beats = 0;
    int  accepted_beats = 0;
    int  windows_seen = 0;
    int  error_count = 0;
    int  phase_id = 0;
    bit  gaps_enabled = 1'b1;
    bit  want_high [CHANNELS] = '{default: 1'b0};

    task automatic accumulate_sample(input t_sample_beat b);
        logic signed [13:0] vc, ic;
        logic signed [27:0] vv, ii, vi;
        logic               pos;
        t_window_result     r;
        int                 c;
        if (b.chan >= CHANNELS) return;
        c  = int'(b.chan);
        vc = {2'b00, b.v_code} - {2'b00, mid_code};
        ic = {2'b00, b.i_code} - {2'b00, mid_code};
        vv = vc * vc;
        ii = ic * ic;
        vi = vc * ic;
        run_v[c]    = run_v[c] + {{22{vc[13]}}, vc};
        run_i[c]    = run_i[c] + {{22{ic[13]}}, ic};
        run_sq_v[c] = run_sq_v[c] + {{19{vv[27]}}, vv};
        run_sq_i[c] = run_sq_i[c] + {{19{ii[27]}}, ii};
        run_pwr[c]  = run_pwr[c] + {{19{vi[27]}}, vi};
        if (run_count[c] != COUNT_LIMIT) run_count[c] = run_count[c] + 25'd1;
        else count_sat[c] = 1'b1;
        pos = (vc > 0);
        if (!was_high[c] && pos) crossings[c] = crossings[c] + 8'd1;
        was_high[c] = pos;
        if (crossings[c] >= window_len) begin
            r.chan      = b.chan;
            r.sum_v     = run_v[c];
            r.sum_i     = run_i[c];
            r.sq_v      = run_sq_v[c][45:0];
            r.sq_i      = run_sq_i[c][45:0];
            r.pwr       = run_pwr[c];
            r.count     = run_count[c];
            r.ovf       = count_sat[c];
            r.last_chan = (c == CHANNELS - 1);
            window_q.push_back(r);
            run_v[c] = '0; run_i[c] = '0; run_sq_v[c] = '0; run_sq_i[c] = '0;
            run_pwr[c] = '0; run_count[c] = '0; was_high[c] = 1'b0;
            crossings[c] = '0; count_sat[c] = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // sender: bursts of random length, separated by random gaps while gaps_enabled is set
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        t_sample_beat nb;
        logic         fire;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            fire = s_axis_tvalid && s_axis_tready;
            if (fire) begin
                accumulate_sample(cur_beat);
                accepted_beats++;
            end
            if (fire || !s_axis_tvalid) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (beat_q.size() > 0) begin
                    nb = beat_q.pop_front();
                    cur_beat = nb;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {nb.i_code, nb.v_code};
                    s_axis_tuser  <= nb.chan;
                    if (burst_left == 0) burst_left = $urandom_range(1, 24);
                    burst_left--;
                    if (burst_left == 0 && gaps_enabled)
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: changing stall pattern, plus one long hold in the pressure phase
    t_ready_mode ready_mode = RDY_ALWAYS;
    int  mode_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge i_clk) begin
        logic rdy;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (phase_id == PRESSURE_PHASE && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                rdy = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    ready_mode = t_ready_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(5, 40);
                end
                mode_left--;
                case (ready_mode)
                    RDY_ALWAYS: rdy = 1'b1;
                    RDY_RANDOM: rdy = 1'($urandom_range(0, 1));
                    default:    rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            m_axis_tready <= rdy;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_window_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (window_q.size() == 0) begin
                report_mismatch("unexpected result beat, channel", 64'(m_axis_tuser[1:0]),
                                '0);
            end else begin
                want = window_q.pop_front();
                windows_seen++;
                check_field("out_channel", 64'(m_axis_tuser[1:0]), 64'(want.chan));
                check_field("count_overflow", 64'(m_axis_tuser[2]), 64'(want.ovf));
                check_field("all_ready", 64'(m_axis_tuser[3]), 64'(want.last_chan));
                check_field("total_v", 64'(m_axis_tdata[35:0]), 64'(want.sum_v));
                check_field("total_i", 64'(m_axis_tdata[OFS_I +: 36]), 64'(want.sum_i));
                check_field("total_v_squared", 64'(m_axis_tdata[OFS_VSQ +: 46]),
                            64'(want.sq_v));
                check_field("total_i_squared", 64'(m_axis_tdata[OFS_ISQ +: 46]),
                            64'(want.sq_i));
                check_field("total_power", 64'(m_axis_tdata[OFS_PWR +: 47]), 64'(want.pwr));
                check_field("sample_count", 64'(m_axis_tdata[OFS_CNT +: 25]),
                            64'(want.count));
            end
        end
    end

    // watchdog on cycles with no traffic at all
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || i_cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("power_meter_window_accumulator_core_test failed");
            $finish;
        end
    end

    task automatic push_beat(input int ch, input int v, input int cur);
        t_sample_beat b;
        b.chan   = ch[1:0];
        b.v_code = v[11:0];
        b.i_code = cur[11:0];
        beat_q.push_back(b);
        queued_beats++;
    endtask

    // alternate each channel's voltage across the midpoint so crossings keep coming
    task automatic push_wave(input int focus);
        int ch;
        int v;
        int cur;
        if (focus >= 0 && $urandom_range(0, 19) != 0) ch = focus;
        else ch = $urandom_range(0, CHANNELS - 1);
        if ($urandom_range(0, 9) == 0) begin
            ch = $urandom_range(0, 3);
            v  = $urandom_range(0, 4095);
        end else begin
            if (!want_high[ch])
                v = (mid_code == 12'hFFF) ? 4095 : $urandom_range(4095, 32'(mid_code) + 1);
            else
                v = $urandom_range(32'(mid_code), 0);
            want_high[ch] = !want_high[ch];
        end
        if ($urandom_range(0, 9) == 0) cur = $urandom_range(0, 1) ? 4095 : 0;
        else cur = $urandom_range(0, 4095);
        push_beat(ch, v, cur);
    endtask

    task automatic set_config(input int win, input int mid);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= CFG_WINDOW;
        i_cfg_wdata <= CFG_DATA_W'(win);
        window_len = win[WIN_W-1:0];
        @(posedge i_clk);
        i_cfg_addr  <= CFG_MIDPOINT;
        i_cfg_wdata <= CFG_DATA_W'(mid);
        mid_code = mid[MID_W-1:0];
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // wait until every beat is taken and every window has come out
    task automatic settle();
        while (accepted_beats != queued_beats || window_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int id, input int win, input int mid, input int n,
                             input int focus, input bit gaps);
        phase_id = id;
        gaps_enabled = gaps;
        if (win >= 0) set_config(win, mid);
        repeat (n) push_wave(focus);
        settle();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // field extremes under the reset settings; channel 3 must be dropped
        push_beat(0, 0, 0);
        push_beat(0, 4095, 4095);
        push_beat(1, 2048, 2048);
        push_beat(1, 2049, 2047);
        push_beat(2, 4095, 0);
        push_beat(2, 0, 4095);
        push_beat(3, 4095, 4095);
        push_beat(3, 0, 0);
        push_beat(0, 2047, 1);
        push_beat(1, 12'hAAA, 12'h555);
        push_beat(2, 12'h555, 12'hAAA);
        push_beat(0, 4095, 2048);
        push_beat(1, 0, 4095);
        push_beat(2, 2048, 0);

        run_phase(0, -1, 0, 280, 2, 1'b1);                                  // reset window
        run_phase(1, 1, 0, 150, -1, 1'b1);                                  // lowest midpoint
        run_phase(PRESSURE_PHASE, 0, 4095, 120, -1, 1'b0);                  // every beat closes
        run_phase(3, 255, 2048, 530, 0, 1'b1);                              // widest window
        run_phase(4, $urandom_range(2, 6), $urandom_range(0, 4095), 200, -1, 1'b1);
        run_phase(5, 1, 2048, 150, -1, 1'b1);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d sample beats over 6 register settings", accepted_beats);
        $display("%0d closed windows checked, %0d mismatches", windows_seen, error_count);
        if (error_count == 0 && window_q.size() == 0)
            $display("power_meter_window_accumulator_core_test passed");
        else
            $display("power_meter_window_accumulator_core_test failed");
        $finish;
    end

endmodule
